// ----- rtl/core/gbe_pkg.sv -----
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the gyro bias estimator.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int THRESH_W   = 15;
    localparam int TIMEOUT_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_GAIN      = 2'd2;

    localparam logic [THRESH_W-1:0]   THRESH_RST  = 15'd48;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST = 16'd300;
    localparam logic [CFG_DATA_W-1:0] GAIN_RST    = 32'd21085;

    typedef struct packed {
        logic [THRESH_W-1:0]  still_threshold;
        logic [TIMEOUT_W-1:0] still_timeout;
    } t_cfg;

endpackage

// ----- rtl/core/gbe_intf.sv -----
// ----------------------------------------------------------------------------
// gbe_intf
// Sample, estimate and register write channels of the gyro bias estimator.
// ----------------------------------------------------------------------------
interface gbe_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;

    modport source (output valid, gyro_x, gyro_y, gyro_z, input ready);
    modport sink   (input valid, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface gbe_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS:0]   fixed_x;
    logic signed [SAMPLE_BITS:0]   fixed_y;
    logic signed [SAMPLE_BITS:0]   fixed_z;
    logic signed [SAMPLE_BITS-1:0] bias_x;
    logic signed [SAMPLE_BITS-1:0] bias_y;
    logic signed [SAMPLE_BITS-1:0] bias_z;
    logic                          is_still;
    logic                          adapting;

    modport source (output valid, fixed_x, fixed_y, fixed_z, bias_x, bias_y, bias_z,
                    is_still, adapting, input ready);
    modport sink   (input valid, fixed_x, fixed_y, fixed_z, bias_x, bias_y, bias_z,
                    is_still, adapting, output ready);
endinterface

interface gbe_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gbe_pkg::CFG_IDX_W-1:0]     index;
    logic [gbe_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gbe_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gbe_cfg_regs
// Threshold, timeout and gain registers behind the write channel.
// ----------------------------------------------------------------------------
module gbe_cfg_regs #(
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gbe_cfg_if.sink                   i_cfg,
    output gbe_pkg::t_cfg             o_cfg,
    output logic [GAIN_FRAC_BITS-1:0] o_gain
);

    gbe_pkg::t_cfg             r_cfg;
    logic [GAIN_FRAC_BITS-1:0] r_gain;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_gain      = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.still_threshold <= gbe_pkg::THRESH_RST;
            r_cfg.still_timeout   <= gbe_pkg::TIMEOUT_RST;
            r_gain                <= gbe_pkg::GAIN_RST[GAIN_FRAC_BITS-1:0];
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gbe_pkg::CFG_STILL_THRESHOLD: begin
                    r_cfg.still_threshold <= i_cfg.data[gbe_pkg::THRESH_W-1:0];
                end
                gbe_pkg::CFG_STILL_TIMEOUT: begin
                    r_cfg.still_timeout <= i_cfg.data[gbe_pkg::TIMEOUT_W-1:0];
                end
                gbe_pkg::CFG_ADAPT_GAIN: begin
                    r_gain <= i_cfg.data[GAIN_FRAC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/gbe_axis.sv -----
// ----------------------------------------------------------------------------
// gbe_axis
// One axis: offset accumulator, corrected sample, stillness test and
// saturating high-pass offset update.
// ----------------------------------------------------------------------------
module gbe_axis #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [gbe_pkg::THRESH_W-1:0]      i_threshold,
    input  logic [GAIN_FRAC_BITS-1:0]         i_gain,
    input  logic                              i_step,
    input  logic                              i_adapt,
    output logic signed [SAMPLE_BITS:0]       o_fixed,
    output logic                              o_calm,
    output logic signed [SAMPLE_BITS-1:0]     o_bias
);

    localparam int ACC_W  = SAMPLE_BITS + GAIN_FRAC_BITS;
    localparam int PROD_W = ACC_W + 2;
    localparam int FIX_W  = SAMPLE_BITS + 1;
    localparam int CMP_W  = (FIX_W > gbe_pkg::THRESH_W) ? FIX_W : gbe_pkg::THRESH_W;

    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [SAMPLE_BITS-1:0] bias_cur;
    logic signed [FIX_W-1:0]       fixed;
    logic [FIX_W-1:0]              mag;
    logic signed [PROD_W-1:0]      fix_ext;
    logic signed [PROD_W-1:0]      gain_ext;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      sum;
    logic                          ovf;
    logic signed [ACC_W-1:0]       sat;

    always_comb begin
        bias_cur = r_acc[ACC_W-1:GAIN_FRAC_BITS];
        fixed    = FIX_W'(i_sample) - FIX_W'(bias_cur);
        mag      = fixed[FIX_W-1] ? FIX_W'(-fixed) : FIX_W'(fixed);
        o_calm   = CMP_W'(mag) <= CMP_W'(i_threshold);
        fix_ext  = PROD_W'(fixed);
        gain_ext = PROD_W'({1'b0, i_gain});
        prod     = fix_ext * gain_ext;
        sum      = PROD_W'(r_acc) + prod;
        ovf      = (sum[PROD_W-1:ACC_W-1] != '0) && (sum[PROD_W-1:ACC_W-1] != '1);
        if (!ovf) begin
            sat = sum[ACC_W-1:0];
        end else if (sum[PROD_W-1]) begin
            sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        n_acc   = i_adapt ? sat : r_acc;
        o_fixed = fixed;
        o_bias  = n_acc[ACC_W-1:GAIN_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_step) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- rtl/core/gyro_bias_estimator_core.sv -----
// An accepted sample beat is held in the input registers, then in the output
// registers as its estimate beat. Throughput: one sample per cycle unless the
// output stalls; the offset accumulators close their update loop in between.
// Reset (synchronous, active low): offsets and stationary count clear,
// registers return to threshold 48, timeout 300, gain 21085.
// ----------------------------------------------------------------------------
// gyro_bias_estimator_core
// Three-axis gyro offset removal with stationary detection and slow
// high-pass offset adaptation.
// ----------------------------------------------------------------------------
module gyro_bias_estimator_core #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gbe_in_if.sink  i_gyro,
    gbe_cfg_if.sink i_cfg,
    gbe_out_if.source o_est
);

    localparam int NAX = 3;

    gbe_pkg::t_cfg             cfg;
    logic [GAIN_FRAC_BITS-1:0] gain;

    logic                                r_in_valid;
    logic signed [SAMPLE_BITS-1:0]       r_smp [NAX];
    logic                                r_out_valid;
    logic signed [SAMPLE_BITS:0]         r_fixed [NAX];
    logic signed [SAMPLE_BITS-1:0]       r_bias [NAX];
    logic                                r_is_still;
    logic                                r_adapting;
    logic [gbe_pkg::TIMEOUT_W-1:0]       r_still_count;
    logic [gbe_pkg::TIMEOUT_W-1:0]       n_still_count;

    logic                                move;
    logic                                all_still;
    logic                                adapt;
    logic [NAX-1:0]                      calm;
    logic signed [SAMPLE_BITS:0]         fixed [NAX];
    logic signed [SAMPLE_BITS-1:0]       bias [NAX];

    gbe_cfg_regs #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg),
        .o_gain  (gain)
    );

    for (genvar a = 0; a < NAX; a++) begin : g_axis
        gbe_axis #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_axis (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_sample    (r_smp[a]),
            .i_threshold (cfg.still_threshold),
            .i_gain      (gain),
            .i_step      (move),
            .i_adapt     (adapt),
            .o_fixed     (fixed[a]),
            .o_calm      (calm[a]),
            .o_bias      (bias[a])
        );
    end

    assign move         = r_in_valid && (!r_out_valid || o_est.ready);
    assign i_gyro.ready = !r_in_valid || move;

    always_comb begin
        all_still     = &calm;
        adapt         = 1'b0;
        n_still_count = r_still_count;
        if (!all_still) begin
            n_still_count = '0;
        end else if (r_still_count < cfg.still_timeout) begin
            n_still_count = r_still_count + gbe_pkg::TIMEOUT_W'(1);
        end else begin
            adapt = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_still_count <= '0;
        end else begin
            if (i_gyro.ready) begin
                r_in_valid <= i_gyro.valid;
            end
            if (move) begin
                r_out_valid   <= 1'b1;
                r_still_count <= n_still_count;
            end else if (o_est.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_gyro.ready && i_gyro.valid) begin
            r_smp[0] <= i_gyro.gyro_x;
            r_smp[1] <= i_gyro.gyro_y;
            r_smp[2] <= i_gyro.gyro_z;
        end
        if (move) begin
            r_fixed    <= fixed;
            r_bias     <= bias;
            r_is_still <= all_still;
            r_adapting <= adapt;
        end
    end

    assign o_est.valid    = r_out_valid;
    assign o_est.fixed_x  = r_fixed[0];
    assign o_est.fixed_y  = r_fixed[1];
    assign o_est.fixed_z  = r_fixed[2];
    assign o_est.bias_x   = r_bias[0];
    assign o_est.bias_y   = r_bias[1];
    assign o_est.bias_z   = r_bias[2];
    assign o_est.is_still = r_is_still;
    assign o_est.adapting = r_adapting;

`ifndef SYNTH
    a_adapt_needs_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_adapting || r_is_still))
        else $error("adapting flagged on a moving sample");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_still_count == '0) && !r_out_valid && !r_in_valid)
        else $error("control state not cleared by reset");

    a_motion_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !all_still) |=> (r_still_count == '0) && !r_adapting)
        else $error("stationary count kept across motion");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && all_still && !adapt) |=>
            (r_still_count == $past(r_still_count) + gbe_pkg::TIMEOUT_W'(1)))
        else $error("stationary count did not advance");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives three-axis gyro samples and register writes into the bias estimator
// core with random gaps and stalls, predicts every estimate beat, and checks
// each one field by field against the prediction or a listed expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     SB           = 16;
    localparam int     GF           = 24;
    localparam longint ACC_MAX      = (longint'(1) << (SB - 1 + GF)) - 1;
    localparam longint ACC_MIN      = -ACC_MAX - 1;
    localparam longint AXIS_MAX     = (longint'(1) << (SB - 1)) - 1;
    localparam longint AXIS_MIN     = -AXIS_MAX - 1;
    localparam int     SETTLE       = 6;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     N_PHASES     = 8;
    localparam int     PHASE_ITEMS  = 210;

    localparam logic [gbe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_REG} t_row_kind;
    typedef enum int {AX_CALM, AX_EDGE, AX_OVER, AX_WILD} t_axis_kind;

    typedef struct {
        logic signed [SB:0]   fixed_x, fixed_y, fixed_z;
        logic signed [SB-1:0] bias_x, bias_y, bias_z;
        logic                 is_still, adapting;
    } t_est;

    typedef struct {
        t_row_kind                      kind;
        logic [gbe_pkg::CFG_IDX_W-1:0]  idx;
        logic [gbe_pkg::CFG_DATA_W-1:0] data;
        logic signed [SB-1:0]           x, y, z;
        bit                             typed;
        t_est                           want;
    } t_row;

    typedef struct {
        int thr;
        int tmo;
        int gain;
    } t_setting;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gbe_in_if  #(.SAMPLE_BITS(SB)) gyro_ch ();
    gbe_out_if #(.SAMPLE_BITS(SB)) est_ch ();
    gbe_cfg_if                     cfg_ch ();

    gyro_bias_estimator_core #(
        .SAMPLE_BITS    (SB),
        .GAIN_FRAC_BITS (GF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gyro  (gyro_ch),
        .i_cfg   (cfg_ch),
        .o_est   (est_ch)
    );

    // predictor state
    logic [gbe_pkg::THRESH_W-1:0]  thr_reg;
    logic [gbe_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [GF-1:0]                 gain_reg;
    logic [15:0]                   still_cnt;
    longint                        bias_acc [3];

    t_est pending_est [$];
    int   fails      = 0;
    int   cycles     = 0;
    int   src_left   = 0;
    bit   src_calm   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_est est_of(input logic signed [SB:0] fx, fy, fz,
                                    input logic signed [SB-1:0] bx, by, bz,
                                    input logic st, ad);
        t_est e;
        e.fixed_x = fx; e.fixed_y = fy; e.fixed_z = fz;
        e.bias_x = bx; e.bias_y = by; e.bias_z = bz;
        e.is_still = st; e.adapting = ad;
        return e;
    endfunction

    function automatic t_row row_chk(input logic signed [SB-1:0] x, y, z, input t_est want);
        t_row r;
        r.kind = ROW_SAMPLE; r.idx = '0; r.data = '0;
        r.x = x; r.y = y; r.z = z;
        r.typed = 1'b1; r.want = want;
        return r;
    endfunction

    function automatic t_row row_smp(input logic signed [SB-1:0] x, y, z);
        t_row r;
        r = row_chk(x, y, z, '{default: '0});
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic t_row row_reg(input logic [gbe_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [gbe_pkg::CFG_DATA_W-1:0] data);
        t_row r;
        r = row_smp(0, 0, 0);
        r.kind = ROW_REG; r.idx = idx; r.data = data;
        return r;
    endfunction

    function automatic t_est predict_estimate(input logic signed [SB-1:0] gx, gy, gz);
        longint smp [3];
        longint fix [3];
        longint mag;
        longint sum;
        bit     still;
        bit     adapt;
        t_est   r;
        smp[0] = gx; smp[1] = gy; smp[2] = gz;
        still = 1'b1;
        adapt = 1'b0;
        for (int a = 0; a < 3; a++) begin
            fix[a] = smp[a] - (bias_acc[a] >>> GF);
            mag = (fix[a] < 0) ? -fix[a] : fix[a];
            if (mag > longint'(thr_reg))
                still = 1'b0;
        end
        if (!still) begin
            still_cnt = '0;
        end else if (still_cnt < timeout_reg) begin
            still_cnt = still_cnt + 16'd1;
        end else begin
            adapt = 1'b1;
            for (int a = 0; a < 3; a++) begin
                sum = bias_acc[a] + fix[a] * longint'(gain_reg);
                if (sum > ACC_MAX) sum = ACC_MAX;
                if (sum < ACC_MIN) sum = ACC_MIN;
                bias_acc[a] = sum;
            end
        end
        r.fixed_x = (SB+1)'(fix[0]);
        r.fixed_y = (SB+1)'(fix[1]);
        r.fixed_z = (SB+1)'(fix[2]);
        r.bias_x = SB'(bias_acc[0] >>> GF);
        r.bias_y = SB'(bias_acc[1] >>> GF);
        r.bias_z = SB'(bias_acc[2] >>> GF);
        r.is_still = still;
        r.adapting = adapt;
        return r;
    endfunction

    function automatic logic signed [SB-1:0] pick_axis(input int a, input t_axis_kind kind);
        longint centre;
        longint d;
        longint v;
        longint span;
        centre = bias_acc[a] >>> GF;
        span = (thr_reg > 64) ? 64 : longint'(thr_reg);
        case (kind)
            AX_CALM: d = longint'($urandom_range(0, 2 * span)) - span;
            AX_EDGE: d = $urandom_range(0, 1) ? longint'(thr_reg) : -longint'(thr_reg);
            AX_OVER: d = $urandom_range(0, 1) ? longint'(thr_reg) + 1 : -longint'(thr_reg) - 1;
            default: return SB'($urandom);
        endcase
        v = centre + d;
        if (v > AXIS_MAX) v = AXIS_MAX;
        if (v < AXIS_MIN) v = AXIS_MIN;
        return SB'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got, want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic check_estimate();
        t_est want;
        if (pending_est.size() == 0) begin
            report_mismatch("estimate beat with nothing expected");
            return;
        end
        want = pending_est.pop_front();
        check_field("fixed_x", est_ch.fixed_x, want.fixed_x);
        check_field("fixed_y", est_ch.fixed_y, want.fixed_y);
        check_field("fixed_z", est_ch.fixed_z, want.fixed_z);
        check_field("bias_x", est_ch.bias_x, want.bias_x);
        check_field("bias_y", est_ch.bias_y, want.bias_y);
        check_field("bias_z", est_ch.bias_z, want.bias_z);
        check_field("is_still", {1'b0, est_ch.is_still}, {1'b0, want.is_still});
        check_field("adapting", {1'b0, est_ch.adapting}, {1'b0, want.adapting});
    endtask

    task automatic settle();
        gyro_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_est.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [SB-1:0] gx, gy, gz,
                               input bit typed, input t_est want);
        int   gap;
        t_est pred;
        gap = draw_wait(src_left, src_calm);
        if (gap > 0) begin
            gyro_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        gyro_ch.valid  <= 1'b1;
        gyro_ch.gyro_x <= gx;
        gyro_ch.gyro_y <= gy;
        gyro_ch.gyro_z <= gz;
        do @(posedge i_clk); while (!gyro_ch.ready);
        pred = predict_estimate(gx, gy, gz);
        pending_est.push_back(typed ? want : pred);
    endtask

    task automatic reg_write(input logic [gbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gbe_pkg::CFG_DATA_W-1:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            gbe_pkg::CFG_STILL_THRESHOLD: thr_reg     = data[gbe_pkg::THRESH_W-1:0];
            gbe_pkg::CFG_STILL_TIMEOUT:   timeout_reg = data[gbe_pkg::TIMEOUT_W-1:0];
            gbe_pkg::CFG_ADAPT_GAIN:      gain_reg    = data[GF-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : est_sink
        int left;
        bit calm;
        int stall;
        left = 0;
        calm = 1'b0;
        est_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(left, calm);
            if (stall > 0) begin
                est_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            est_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!est_ch.valid);
            check_estimate();
        end
    end

    initial begin : stimulus
        t_row                 dir_rows [$];
        t_setting             fixed_settings [5];
        t_setting             s;
        logic signed [SB-1:0] ax [3];
        int                   n_left;
        int                   run;
        int                   noise;
        t_axis_kind           kind;

        gyro_ch.valid  <= 1'b0;
        gyro_ch.gyro_x <= '0;
        gyro_ch.gyro_y <= '0;
        gyro_ch.gyro_z <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;

        thr_reg     = gbe_pkg::THRESH_RST;
        timeout_reg = gbe_pkg::TIMEOUT_RST;
        gain_reg    = gbe_pkg::GAIN_RST[GF-1:0];
        still_cnt   = '0;
        bias_acc    = '{0, 0, 0};

        fixed_settings = '{
            '{48, 20, 21085},
            '{0, 0, 24'hFF_FFFF},
            '{32767, 3, 24'hFF_FFFF},
            '{200, 65535, 1000},
            '{100, 2, 0}
        };

        dir_rows = '{
            row_chk(0, 0, 0, est_of(0, 0, 0, 0, 0, 0, 1, 0)),
            row_chk(32767, -32768, 0, est_of(32767, -32768, 0, 0, 0, 0, 0, 0)),
            row_chk(48, -48, 48, est_of(48, -48, 48, 0, 0, 0, 1, 0)),
            row_chk(0, 49, 0, est_of(0, 49, 0, 0, 0, 0, 0, 0)),
            row_chk(-32768, -32768, -32768,
                    est_of(-32768, -32768, -32768, 0, 0, 0, 0, 0)),
            row_reg(gbe_pkg::CFG_STILL_TIMEOUT, 32'd4),
            row_chk(1, -1, 0, est_of(1, -1, 0, 0, 0, 0, 1, 0)),
            row_chk(1, -1, 0, est_of(1, -1, 0, 0, 0, 0, 1, 0)),
            row_chk(1, -1, 0, est_of(1, -1, 0, 0, 0, 0, 1, 0)),
            row_chk(1, -1, 0, est_of(1, -1, 0, 0, 0, 0, 1, 0)),
            row_smp(1, -1, 0),
            row_reg(gbe_pkg::CFG_STILL_TIMEOUT, 32'd2),
            row_smp(2, 3, -4),
            row_reg(gbe_pkg::CFG_STILL_TIMEOUT, 32'd0),
            row_reg(gbe_pkg::CFG_STILL_THRESHOLD, 32'd32767),
            row_reg(gbe_pkg::CFG_ADAPT_GAIN, 32'h00FF_FFFF),
            row_reg(CFG_UNUSED, 32'hFFFF_FFFF),
            row_smp(32767, 32767, 32767),
            row_smp(32767, -32768, 32767),
            row_smp(-32768, -32768, -32768),
            row_smp(0, 0, 0),
            row_smp(-32768, 0, 32767),
            row_reg(gbe_pkg::CFG_STILL_THRESHOLD, 32'd0),
            row_reg(gbe_pkg::CFG_ADAPT_GAIN, 32'd0),
            row_smp(5, 5, 5),
            row_reg(gbe_pkg::CFG_STILL_TIMEOUT, 32'h0000_FFFF),
            row_smp(-7, 0, 7)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG)
                reg_write(dir_rows[r].idx, dir_rows[r].data);
            else
                send_sample(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                            dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 5) begin
                s = fixed_settings[ph];
                reg_write(gbe_pkg::CFG_STILL_THRESHOLD, s.thr);
                reg_write(gbe_pkg::CFG_STILL_TIMEOUT, s.tmo);
                reg_write(gbe_pkg::CFG_ADAPT_GAIN, s.gain);
            end else begin
                s.thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 300);
                s.tmo = $urandom_range(0, 40);
                s.gain = $urandom_range(0, 24'hFF_FFFF);
                // junk above the register width must be dropped
                reg_write(gbe_pkg::CFG_STILL_THRESHOLD, ($urandom & ~32'h7FFF) | s.thr);
                reg_write(gbe_pkg::CFG_STILL_TIMEOUT, ($urandom & ~32'hFFFF) | s.tmo);
                reg_write(gbe_pkg::CFG_ADAPT_GAIN, ($urandom & ~32'hFF_FFFF) | s.gain);
                reg_write(CFG_UNUSED, $urandom);
            end

            n_left = PHASE_ITEMS;
            while (n_left > 0) begin
                run   = $urandom_range(4, 60);
                noise = $urandom_range(0, 3);
                for (int k = 0; k < run + noise && n_left > 0; k++) begin
                    for (int a = 0; a < 3; a++) begin
                        if (k < run)
                            kind = ($urandom_range(0, 7) == 0) ? AX_EDGE : AX_CALM;
                        else
                            kind = $urandom_range(0, 1) ? AX_OVER : AX_WILD;
                        ax[a] = pick_axis(a, kind);
                    end
                    send_sample(ax[0], ax[1], ax[2], 1'b0, '{default: '0});
                    n_left--;
                end
            end
        end

        settle();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
